/* rtl/crc16fr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fr_pkg
// Shared constants, types and the CRC-16/MODBUS byte update for the frame
// receiver.
// ----------------------------------------------------------------------------
package crc16fr_pkg;

    // Largest payload a frame may carry
    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);

    // Result field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = 5;
    localparam int CRC_W  = 16;

    // Output stream data width (27 bits of fields, padded to whole bytes)
    localparam int M_DATA_W = 32;

    // Frame markers and CRC constants
    localparam logic [BYTE_W-1:0] SYNC_1   = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_2   = 8'h5A;
    localparam logic [BYTE_W-1:0] TAIL     = 8'hFF;
    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;

    // Controller to datapath commands
    typedef struct packed {
        logic start;       // begin a new frame: clear count, seed CRC with A5
        logic crc_upd;     // fold the accepted byte into the CRC
        logic load_len;    // capture length byte
        logic load_cmd;    // capture command byte, clear payload count
        logic store;       // write payload byte, advance count
        logic load_crc_hi; // capture received CRC high byte
        logic drain_start; // rewind the drain index
        logic rd_en;       // read payload store at the drain index
        logic out_load;    // load the output register, advance drain index
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_sync_1;
        logic is_sync_2;
        logic is_tail;
        logic len_ok;
        logic len_zero;
        logic pay_last;
        logic crc_match;
        logic drain_last;
        logic out_free;
    } t_dp_sts;

    // Reflected CRC-16 update over one byte, one bit per step
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    localparam logic [CRC_W-1:0] CRC_SEED = crc16_byte(CRC_INIT, SYNC_1);

endpackage
`default_nettype wire

/* rtl/crc16fr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crc16fr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/crc16fr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fr_dp
// Datapath: frame fields, running CRC, payload store, drain index and the
// output register.
// ----------------------------------------------------------------------------
module crc16fr_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [crc16fr_pkg::BYTE_W-1:0] i_byte,
    input  wire crc16fr_pkg::t_ctrl_cmd         i_cmd,
    output crc16fr_pkg::t_dp_sts                o_sts,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [crc16fr_pkg::BYTE_W-1:0]      o_command,
    output logic [crc16fr_pkg::LEN_W-1:0]       o_length,
    output logic [crc16fr_pkg::IDX_W-1:0]       o_index,
    output logic [crc16fr_pkg::BYTE_W-1:0]      o_payload,
    output logic                                o_has_data,
    output logic                                o_last
);
    import crc16fr_pkg::*;

    logic [CRC_W-1:0]  r_crc;
    logic [BYTE_W-1:0] r_crc_hi;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_cmd;
    logic [LEN_W-1:0]  r_count;
    logic [LEN_W-1:0]  r_idx;
    logic [BYTE_W-1:0] rd_data;

    logic              r_ovalid;
    logic [BYTE_W-1:0] r_ocmd;
    logic [LEN_W-1:0]  r_olen;
    logic [IDX_W-1:0]  r_oidx;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_ohas;
    logic              r_olast;

    logic [LEN_W:0] count_next;
    logic [LEN_W:0] idx_next;

    assign count_next = {1'b0, r_count} + (LEN_W+1)'(1);
    assign idx_next   = {1'b0, r_idx} + (LEN_W+1)'(1);

    always_comb begin
        o_sts            = '0;
        o_sts.is_sync_1  = (i_byte == SYNC_1);
        o_sts.is_sync_2  = (i_byte == SYNC_2);
        o_sts.is_tail    = (i_byte == TAIL);
        o_sts.len_ok     = (i_byte <= BYTE_W'(MAX_PAYLOAD));
        o_sts.len_zero   = (r_len == '0);
        o_sts.pay_last   = (count_next >= {1'b0, r_len});
        o_sts.crc_match  = ({r_crc_hi, i_byte} == r_crc);
        o_sts.drain_last = (idx_next >= {1'b0, r_len});
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

    // Control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_INIT;
            r_crc_hi <= '0;
            r_len    <= '0;
            r_cmd    <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_crc <= CRC_SEED;
            end else if (i_cmd.crc_upd) begin
                r_crc <= crc16_byte(r_crc, i_byte);
            end
            if (i_cmd.start || i_cmd.load_cmd) begin
                r_count <= '0;
            end else if (i_cmd.store) begin
                r_count <= count_next[LEN_W-1:0];
            end
            if (i_cmd.load_len) begin
                r_len <= i_byte[LEN_W-1:0];
            end
            if (i_cmd.load_cmd) begin
                r_cmd <= i_byte;
            end
            if (i_cmd.load_crc_hi) begin
                r_crc_hi <= i_byte;
            end
            if (i_cmd.drain_start) begin
                r_idx <= '0;
            end else if (i_cmd.out_load) begin
                r_idx <= idx_next[LEN_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    crc16fr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    // Output payload register; an empty frame gives one data-less result
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ocmd <= r_cmd;
            if (r_len == '0) begin
                r_olen  <= '0;
                r_oidx  <= '0;
                r_obyte <= '0;
                r_ohas  <= 1'b0;
                r_olast <= 1'b1;
            end else begin
                r_olen  <= r_len;
                r_oidx  <= r_idx[IDX_W-1:0];
                r_obyte <= rd_data;
                r_ohas  <= 1'b1;
                r_olast <= (idx_next == {1'b0, r_len});
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_command   = r_ocmd;
    assign o_length    = r_olen;
    assign o_index     = r_oidx;
    assign o_payload   = r_obyte;
    assign o_has_data  = r_ohas;
    assign o_last      = r_olast;

endmodule
`default_nettype wire

/* rtl/crc16fr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fr_ctrl
// Controller: frame phase tracking on accepted bytes and the payload drain.
// ----------------------------------------------------------------------------
module crc16fr_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire crc16fr_pkg::t_dp_sts   i_sts,
    output crc16fr_pkg::t_ctrl_cmd      o_cmd
);
    import crc16fr_pkg::*;

    localparam logic [3:0] PH_HUNT = 4'd0;
    localparam logic [3:0] PH_SYNC = 4'd1;
    localparam logic [3:0] PH_LEN  = 4'd2;
    localparam logic [3:0] PH_CMD  = 4'd3;
    localparam logic [3:0] PH_PAY  = 4'd4;
    localparam logic [3:0] PH_CRCH = 4'd5;
    localparam logic [3:0] PH_CRCL = 4'd6;
    localparam logic [3:0] PH_TAIL = 4'd7;
    localparam logic [3:0] ST_RD   = 4'd8;
    localparam logic [3:0] ST_LOAD = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       in_fire;
    logic [3:0] misfit_state;

    assign o_in_ready   = !r_state[3];
    assign in_fire      = i_in_valid && o_in_ready;
    assign misfit_state = i_sts.is_sync_1 ? PH_SYNC : PH_HUNT;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            PH_HUNT: begin
                if (in_fire && i_sts.is_sync_1) begin
                    o_cmd.start = 1'b1;
                    n_state     = PH_SYNC;
                end
            end
            PH_SYNC: begin
                if (in_fire) begin
                    if (i_sts.is_sync_2) begin
                        o_cmd.crc_upd = 1'b1;
                        n_state       = PH_LEN;
                    end else begin
                        o_cmd.start = i_sts.is_sync_1;
                        n_state     = misfit_state;
                    end
                end
            end
            PH_LEN: begin
                if (in_fire) begin
                    if (i_sts.len_ok) begin
                        o_cmd.load_len = 1'b1;
                        o_cmd.crc_upd  = 1'b1;
                        n_state        = PH_CMD;
                    end else begin
                        o_cmd.start = i_sts.is_sync_1;
                        n_state     = misfit_state;
                    end
                end
            end
            PH_CMD: begin
                if (in_fire) begin
                    o_cmd.load_cmd = 1'b1;
                    o_cmd.crc_upd  = 1'b1;
                    n_state        = i_sts.len_zero ? PH_CRCH : PH_PAY;
                end
            end
            PH_PAY: begin
                if (in_fire) begin
                    o_cmd.store   = 1'b1;
                    o_cmd.crc_upd = 1'b1;
                    if (i_sts.pay_last) begin
                        n_state = PH_CRCH;
                    end
                end
            end
            PH_CRCH: begin
                if (in_fire) begin
                    o_cmd.load_crc_hi = 1'b1;
                    n_state           = PH_CRCL;
                end
            end
            PH_CRCL: begin
                if (in_fire) begin
                    if (i_sts.crc_match) begin
                        n_state = PH_TAIL;
                    end else begin
                        o_cmd.start = i_sts.is_sync_1;
                        n_state     = misfit_state;
                    end
                end
            end
            PH_TAIL: begin
                if (in_fire) begin
                    if (i_sts.is_tail) begin
                        o_cmd.drain_start = 1'b1;
                        n_state           = ST_RD;
                    end else begin
                        o_cmd.start = i_sts.is_sync_1;
                        n_state     = misfit_state;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_sts.drain_last ? PH_HUNT : ST_RD;
                end
            end
            default: begin
                n_state = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* rtl/crc16_frame_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Byte-stream deframer for A5 5A / length / command / payload / CRC / FF
// frames with a CRC-16/MODBUS check, releasing the payload as a stream.
// ----------------------------------------------------------------------------
// Feed received bytes on the slave stream, one byte per transfer. While the
// block is looking for or collecting a frame it takes one byte every cycle.
// Once a frame with a matching CRC and a correct FF tail has arrived, the input
// is held off while the payload is read back from the payload store: each
// result takes one store read (ST_RD) and then one load into the output
// register (ST_LOAD), which waits while the sink stalls. An empty frame
// yields a single result with has_data low. The last result of a frame may
// still wait in the output register while the next bytes are taken in.
// Frames with a bad CRC, a bad tail or a length above MAX_PAYLOAD vanish
// without any output; an A5 byte at a misfit point starts a fresh frame.
// ----------------------------------------------------------------------------
module crc16_frame_receiver (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Slave stream: received bytes
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [7:0]                       i_s_tdata,  // [7:0] rx_byte
    // Master stream: released frame contents
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [7:0] command, [13:8] payload_length, [18:14] byte_index,
    // [26:19] payload_byte, [31:27] zero
    output logic [crc16fr_pkg::M_DATA_W-1:0]      o_m_tdata,
    output logic                                  o_m_tlast,
    output logic                                  o_m_tuser   // [0] has_data
);
    import crc16fr_pkg::*;

    t_ctrl_cmd         s_cmd;
    t_dp_sts           s_sts;
    logic [BYTE_W-1:0] out_cmd;
    logic [LEN_W-1:0]  out_len;
    logic [IDX_W-1:0]  out_idx;
    logic [BYTE_W-1:0] out_byte;

    // Sequence the frame phases and the drain
    crc16fr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    // Hold frame fields, CRC, payload store and the output register
    crc16fr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_s_tdata),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_command   (out_cmd),
        .o_length    (out_len),
        .o_index     (out_idx),
        .o_payload   (out_byte),
        .o_has_data  (o_m_tuser),
        .o_last      (o_m_tlast)
    );

    // Pack result fields, lowest first, padded to whole bytes
    assign o_m_tdata = {(M_DATA_W - 2*BYTE_W - LEN_W - IDX_W)'(0),
                        out_byte, out_idx, out_len, out_cmd};

    // The drain never overlaps byte acceptance
    a_drain_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.rd_en || s_cmd.out_load) |-> !o_s_tready)
        else $error("payload drain active while input is accepted");

    // A good tail always stops the input on the next cycle
    a_tail_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && s_cmd.drain_start) |=> !o_s_tready)
        else $error("input not held off after frame tail");

    // The output register is loaded only when it is free
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !s_cmd.out_load)
        else $error("output register overwritten while stalled");

    // A data-less result is always the only one of its frame
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && o_m_tdata[13:8] == 6'd0))
        else $error("empty-frame result without last flag");

endmodule
`default_nettype wire

/* test/tb_crc16_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_frame_receiver
// Self-checking bench for the frame receiver. It feeds byte streams made of
// good frames, corrupted frames, broken frame prefixes and line noise. A
// scoreboard class mirrors the deframer state and queues the payload results
// each released frame should give. It compares every output transfer field by
// field and counts any mismatch. Both stream sides idle at random, the sink
// holds off once for a long stretch, and the sender pauses once until drained.
// ----------------------------------------------------------------------------
module tb_crc16_frame_receiver;

    localparam int MAXP = crc16fr_pkg::MAX_PAYLOAD;

    typedef enum logic [2:0] {
        PH_HUNT, PH_SYNC2, PH_LENGTH, PH_COMMAND,
        PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO, PH_TAIL
    } rx_phase_t;

    typedef struct {
        logic [7:0] command;
        logic [5:0] length;
        logic [4:0] index;
        logic [7:0] data;
        logic       has_data;
        logic       last;
    } frame_result_t;

    class frame_scoreboard;
        rx_phase_t     phase;
        int unsigned   count;
        logic [5:0]    length;
        logic [7:0]    command;
        logic [15:0]   crc;
        logic [7:0]    crc_high;
        logic [7:0]    store [MAXP];
        frame_result_t awaited [$];
        int            mismatches;
        int            results_seen;
        int            bytes_seen;
        int            frames_released;

        function new();
            phase           = PH_HUNT;
            count           = 0;
            length          = '0;
            command         = '0;
            crc             = crc16fr_pkg::CRC_INIT;
            crc_high        = '0;
            mismatches      = 0;
            results_seen    = 0;
            bytes_seen      = 0;
            frames_released = 0;
        endfunction

        // Reflected CRC-16, one input bit at a time
        static function logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] r;
            r = c;
            for (int k = 0; k < 8; k++) begin
                r = {1'b0, r[15:1]} ^ ((r[0] ^ b[k]) ? crc16fr_pkg::CRC_POLY : 16'h0000);
            end
            return r;
        endfunction

        // A misfit byte either opens a fresh frame (A5) or drops back to hunting
        function void misfit(input logic [7:0] b);
            if (b == crc16fr_pkg::SYNC_1) begin
                count = 0;
                crc   = crc_fold(crc16fr_pkg::CRC_INIT, crc16fr_pkg::SYNC_1);
                phase = PH_SYNC2;
            end else begin
                phase = PH_HUNT;
            end
        endfunction

        function void release_frame();
            frame_result_t r;
            frames_released++;
            if (length == 0) begin
                r = '{command, 6'd0, 5'd0, 8'd0, 1'b0, 1'b1};
                awaited.push_back(r);
            end else begin
                for (int i = 0; i < length; i++) begin
                    r = '{command, length, i[4:0], store[i], 1'b1, (i + 1 == length)};
                    awaited.push_back(r);
                end
            end
        endfunction

        // Advance the mirrored deframer by one accepted byte
        function void note_byte(input logic [7:0] b);
            bytes_seen++;
            case (phase)
                PH_HUNT: begin
                    if (b == crc16fr_pkg::SYNC_1) misfit(b);
                end
                PH_SYNC2: begin
                    if (b == crc16fr_pkg::SYNC_2) begin
                        crc   = crc_fold(crc, b);
                        phase = PH_LENGTH;
                    end else begin
                        misfit(b);
                    end
                end
                PH_LENGTH: begin
                    if (b > MAXP) begin
                        misfit(b);
                    end else begin
                        length = b[5:0];
                        crc    = crc_fold(crc, b);
                        phase  = PH_COMMAND;
                    end
                end
                PH_COMMAND: begin
                    command = b;
                    crc     = crc_fold(crc, b);
                    count   = 0;
                    phase   = (length == 0) ? PH_CRC_HI : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (count < MAXP) store[count] = b;
                    crc = crc_fold(crc, b);
                    count++;
                    if (count >= length) phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    crc_high = b;
                    phase    = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    if ({crc_high, b} == crc) phase = PH_TAIL;
                    else misfit(b);
                end
                default: begin
                    if (b == crc16fr_pkg::TAIL) begin
                        release_frame();
                        phase = PH_HUNT;
                    end else begin
                        misfit(b);
                    end
                end
            endcase
        endfunction

        function string describe(input frame_result_t r);
            return $sformatf("cmd %02h len %0d idx %0d data %02h has_data %0b last %0b",
                             r.command, r.length, r.index, r.data, r.has_data, r.last);
        endfunction

        function void flag(input string msg);
            mismatches++;
            if (mismatches <= 10) $display("ERROR %0t: %s", $time, msg);
        endfunction

        // Compare one output transfer with the oldest awaited result
        function void check_result(input logic [crc16fr_pkg::M_DATA_W-1:0] tdata,
                                   input logic tlast, input logic tuser);
            frame_result_t got;
            frame_result_t want;
            got = '{tdata[7:0], tdata[13:8], tdata[18:14], tdata[26:19], tuser, tlast};
            results_seen++;
            if (awaited.size() == 0) begin
                flag({"result with nothing awaited: ", describe(got)});
                return;
            end
            want = awaited.pop_front();
            if (got.command !== want.command || got.length !== want.length ||
                got.index !== want.index || got.data !== want.data ||
                got.has_data !== want.has_data || got.last !== want.last) begin
                flag({"expected ", describe(want), " / actual ", describe(got)});
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'h00;
    logic        i_m_tready = 1'b0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire [crc16fr_pkg::M_DATA_W-1:0] o_m_tdata;
    wire         o_m_tlast;
    wire         o_m_tuser;

    frame_scoreboard sb = new();
    logic [7:0]      frame_buf [$];
    bit              sender_calm = 1'b0;

    crc16_frame_receiver uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TIMEOUT: awaited results left %0d", sb.awaited.size());
        $display("crc16_frame_receiver: mismatch");
        $finish;
    end

    // Offer one byte, idling at random first; return at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        while (!sender_calm && $urandom_range(99) < 17) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_byte(b);
    endtask

    task automatic send_buf();
        foreach (frame_buf[i]) send_byte(frame_buf[i]);
    endtask

    // Build a well-formed frame; fill < 0 gives random payload bytes
    task automatic build_frame(input int len, input logic [7:0] cmd, input int fill);
        logic [15:0] c;
        frame_buf = {crc16fr_pkg::SYNC_1, crc16fr_pkg::SYNC_2, 8'(len), cmd};
        for (int i = 0; i < len; i++) begin
            frame_buf.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
        end
        c = crc16fr_pkg::CRC_INIT;
        foreach (frame_buf[i]) c = frame_scoreboard::crc_fold(c, frame_buf[i]);
        frame_buf.push_back(c[15:8]);
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(crc16fr_pkg::TAIL);
    endtask

    // Drop valid and hold until every awaited result has been taken
    task automatic drain_all();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    // Sink: check each transfer, stall at random, one long hold-off
    initial begin : sink
        int hold_left;
        bit long_hold_done;
        hold_left      = 0;
        long_hold_done = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
            if (!long_hold_done && sb.results_seen >= 30) begin
                hold_left      = 400;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (sb.results_seen >= 60 && sb.results_seen < 110) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 17);
            end
        end
    end

    initial begin : stimulus
        int fed;
        int frames;
        int len;
        int pick;
        int cut;
        logic [7:0] b;
        fed    = 0;
        frames = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Restart on A5 while expecting 5A, then an empty frame
        send_byte(crc16fr_pkg::SYNC_1);
        build_frame(0, 8'hFF, 0);
        send_buf();
        // Oversized length, plain and A5, the latter reopening a frame
        send_byte(crc16fr_pkg::SYNC_1);
        send_byte(crc16fr_pkg::SYNC_2);
        send_byte(8'h21);
        send_byte(crc16fr_pkg::SYNC_1);
        send_byte(crc16fr_pkg::SYNC_2);
        build_frame(1, 8'h00, 0);
        send_buf();

        while (fed < 320) begin
            pick = $urandom_range(99);
            cut  = $urandom_range(99);
            len  = (cut < 6) ? MAXP : (cut < 20) ? $urandom_range(9, MAXP - 1)
                                                 : $urandom_range(0, 8);
            build_frame(len, 8'($urandom_range(255)), -1);
            if (pick < 62) begin
                // good frame, left as built
            end else if (pick < 70) begin
                b = 8'($urandom_range(1, 255));
                frame_buf[4 + len + $urandom_range(1)] ^= b;
            end else if (pick < 77) begin
                b = ($urandom_range(2) == 0) ? crc16fr_pkg::SYNC_1
                                             : 8'($urandom_range(254));
                frame_buf[6 + len] = b;
            end else if (pick < 82) begin
                frame_buf[5 + len] = crc16fr_pkg::SYNC_1;
            end else if (pick < 88) begin
                frame_buf    = frame_buf[0:2];
                frame_buf[2] = 8'($urandom_range(MAXP + 1, 255));
            end else if (pick < 94) begin
                frame_buf = frame_buf[0:$urandom_range(0, frame_buf.size() - 2)];
            end else begin
                // line noise, not counted in the fed total; it may open with A5
                frame_buf = {};
                repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom_range(255)));
                if ($urandom_range(3) == 0) frame_buf[0] = crc16fr_pkg::SYNC_1;
                fed -= frame_buf.size();
            end
            sender_calm = (fed >= 150 && fed < 230);
            send_buf();
            fed += frame_buf.size();
            frames++;
            if (frames == 18) drain_all();
        end

        drain_all();
        repeat (20) @(posedge i_clk);
        $display("Fed %0d bytes: good, corrupted, truncated and oversized frames plus noise.",
                 sb.bytes_seen);
        $display("Released %0d frames, checked %0d results, %0d mismatches.",
                 sb.frames_released, sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("crc16_frame_receiver: match");
        end else begin
            $display("crc16_frame_receiver: mismatch");
        end
        $finish;
    end

endmodule
